// File: sv/eulrot_pkg.sv
// ---------------------------------------------------------------------------
// Euler rotation matrix builder package
// Types, sine table and fixed-point helpers for the matrix pipeline.
// ---------------------------------------------------------------------------
package eulrot_pkg;

   typedef logic signed [7:0] angle_type;
   typedef logic signed [7:0] trig_type;
   typedef logic signed [8:0] sum_type;
   typedef logic signed [15:0] prod_type;

   localparam int AngleWidth = 8;
   localparam int EntryCount = 9;
   localparam int ReqDataWidth = 3 * AngleWidth;
   localparam int RspDataWidth = EntryCount * AngleWidth;

   // Sine of k * pi / 64 in 6-bit fraction, for k = 0 to 32.
   localparam logic [6:0] QuarterSine [33] = '{
      7'd0,  7'd3,  7'd6,  7'd9,  7'd12, 7'd16, 7'd19, 7'd22,
      7'd24, 7'd27, 7'd30, 7'd33, 7'd36, 7'd38, 7'd41, 7'd43,
      7'd45, 7'd47, 7'd49, 7'd51, 7'd53, 7'd55, 7'd56, 7'd58,
      7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd63, 7'd64, 7'd64,
      7'd64
   };

   function automatic trig_type sine_lookup(input logic [6:0] phase);
      logic [6:0] idx;
      logic       neg;
      begin
         if (phase <= 7'd32) begin
            idx = phase;
            neg = 1'b0;
         end else if (phase <= 7'd64) begin
            idx = 7'd64 - phase;
            neg = 1'b0;
         end else if (phase <= 7'd96) begin
            idx = phase - 7'd64;
            neg = 1'b1;
         end else begin
            idx = 7'd0 - phase;
            neg = 1'b1;
         end
         sine_lookup = neg ? -$signed({1'b0, QuarterSine[idx[5:0]]})
                           : $signed({1'b0, QuarterSine[idx[5:0]]});
      end
   endfunction

   function automatic trig_type cosine_lookup(input logic [6:0] phase);
      logic [6:0] shifted;
      begin
         shifted = phase + 7'd32;
         cosine_lookup = sine_lookup(shifted);
      end
   endfunction

   // Product of two 6-bit-fraction values, floored back to 6 fraction bits.
   function automatic trig_type fx_mul(input trig_type a, input trig_type b);
      prod_type p;
      begin
         p = prod_type'(a) * prod_type'(b);
         fx_mul = p[13:6];
      end
   endfunction

   function automatic trig_type add_sat(input trig_type a, input trig_type b,
                                        input logic neg_a);
      sum_type s;
      begin
         s = neg_a ? (sum_type'(b) - sum_type'(a)) : (sum_type'(a) + sum_type'(b));
         if (s > sum_type'(127)) begin
            add_sat = 8'sd127;
         end else if (s < sum_type'(-128)) begin
            add_sat = -8'sd128;
         end else begin
            add_sat = s[7:0];
         end
      end
   endfunction

endpackage

// File: sv/euler_rotation_matrix_builder.sv
// ---------------------------------------------------------------------------
// Euler rotation matrix builder
// An accepted item reaches rsp_tdata through the registered stages listed below.
// Throughput is one item per cycle; only a stalled rsp_tready holds it back.
// Stages: sine table, first products, nested products, sums with saturation.
// Synchronous reset empties the pipeline; payload registers are not cleared.
// ---------------------------------------------------------------------------
module euler_rotation_matrix_builder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // x_angle [7:0], y_angle [15:8], z_angle [23:16]
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // r00 [7:0], r01 [15:8], r02 [23:16], r10 [31:24], r11 [39:32],
   // r12 [47:40], r20 [55:48], r21 [63:56], r22 [71:64]
   output logic [71:0] rsp_tdata
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic ld1, ld2, ld3, ld4;

   eulrot_pkg::trig_type sx_ff, cx_ff, sy_ff, cy_ff, sz_ff, cz_ff;
   eulrot_pkg::trig_type sx_in, cx_in, sy_in, cy_in, sz_in, cz_in;

   eulrot_pkg::trig_type sxsy_ff, sycz_ff, sysz_ff, cycz_ff, cysz_ff, sxcy_ff;
   eulrot_pkg::trig_type cxcy_ff, cxsz_ff, cxcz_ff, sxsz_ff, sxcz_ff;
   eulrot_pkg::trig_type cx2_ff, cz2_ff, sz2_ff, sy2_ff;

   eulrot_pkg::trig_type ta_ff, tb_ff, tc_ff, td_ff;
   eulrot_pkg::trig_type cycz3_ff, cysz3_ff, sy3_ff, cxsz3_ff, cxcz3_ff;
   eulrot_pkg::trig_type sxcy3_ff, sxsz3_ff, sxcz3_ff, cxcy3_ff;

   logic [eulrot_pkg::RspDataWidth-1:0] out_ff, out_in;

   assign ld4 = !v4_ff || rsp_tready;
   assign ld3 = !v3_ff || ld4;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;
   assign req_tready = ld1;
   assign rsp_tvalid = v4_ff;
   assign rsp_tdata = out_ff;

   always_comb begin
      sx_in = eulrot_pkg::sine_lookup(req_tdata[6:0]);
      cx_in = eulrot_pkg::cosine_lookup(req_tdata[6:0]);
      sy_in = eulrot_pkg::sine_lookup(req_tdata[14:8]);
      cy_in = eulrot_pkg::cosine_lookup(req_tdata[14:8]);
      sz_in = eulrot_pkg::sine_lookup(req_tdata[22:16]);
      cz_in = eulrot_pkg::cosine_lookup(req_tdata[22:16]);
   end

   always_comb begin
      out_in[7:0]   = eulrot_pkg::add_sat(cycz3_ff, 8'sd0, 1'b0);
      out_in[15:8]  = eulrot_pkg::add_sat(cysz3_ff, 8'sd0, 1'b1);
      out_in[23:16] = sy3_ff;
      out_in[31:24] = eulrot_pkg::add_sat(ta_ff, cxsz3_ff, 1'b0);
      out_in[39:32] = eulrot_pkg::add_sat(tb_ff, cxcz3_ff, 1'b1);
      out_in[47:40] = eulrot_pkg::add_sat(sxcy3_ff, 8'sd0, 1'b1);
      out_in[55:48] = eulrot_pkg::add_sat(tc_ff, sxsz3_ff, 1'b1);
      out_in[63:56] = eulrot_pkg::add_sat(td_ff, sxcz3_ff, 1'b0);
      out_in[71:64] = eulrot_pkg::add_sat(cxcy3_ff, 8'sd0, 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ld1) begin
            v1_ff <= req_tvalid;
         end
         if (ld2) begin
            v2_ff <= v1_ff;
         end
         if (ld3) begin
            v3_ff <= v2_ff;
         end
         if (ld4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         sx_ff <= sx_in;
         cx_ff <= cx_in;
         sy_ff <= sy_in;
         cy_ff <= cy_in;
         sz_ff <= sz_in;
         cz_ff <= cz_in;
      end
      if (ld2) begin
         sxsy_ff <= eulrot_pkg::fx_mul(sx_ff, sy_ff);
         sycz_ff <= eulrot_pkg::fx_mul(sy_ff, cz_ff);
         sysz_ff <= eulrot_pkg::fx_mul(sy_ff, sz_ff);
         cycz_ff <= eulrot_pkg::fx_mul(cy_ff, cz_ff);
         cysz_ff <= eulrot_pkg::fx_mul(cy_ff, sz_ff);
         sxcy_ff <= eulrot_pkg::fx_mul(sx_ff, cy_ff);
         cxcy_ff <= eulrot_pkg::fx_mul(cx_ff, cy_ff);
         cxsz_ff <= eulrot_pkg::fx_mul(cx_ff, sz_ff);
         cxcz_ff <= eulrot_pkg::fx_mul(cx_ff, cz_ff);
         sxsz_ff <= eulrot_pkg::fx_mul(sx_ff, sz_ff);
         sxcz_ff <= eulrot_pkg::fx_mul(sx_ff, cz_ff);
         cx2_ff  <= cx_ff;
         cz2_ff  <= cz_ff;
         sz2_ff  <= sz_ff;
         sy2_ff  <= sy_ff;
      end
      if (ld3) begin
         ta_ff    <= eulrot_pkg::fx_mul(sxsy_ff, cz2_ff);
         tb_ff    <= eulrot_pkg::fx_mul(sxsy_ff, sz2_ff);
         tc_ff    <= eulrot_pkg::fx_mul(cx2_ff, sycz_ff);
         td_ff    <= eulrot_pkg::fx_mul(cx2_ff, sysz_ff);
         cycz3_ff <= cycz_ff;
         cysz3_ff <= cysz_ff;
         sy3_ff   <= sy2_ff;
         cxsz3_ff <= cxsz_ff;
         cxcz3_ff <= cxcz_ff;
         sxcy3_ff <= sxcy_ff;
         sxsz3_ff <= sxsz_ff;
         sxcz3_ff <= sxcz_ff;
         cxcy3_ff <= cxcy_ff;
      end
      if (ld4) begin
         out_ff <= out_in;
      end
   end

   // The pipeline refuses an item only when every stage is full and the output stalls.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && rsp_tvalid && !rsp_tready))
      else $error("input stalled while the pipeline has room");

   // A full, stalled pipeline keeps every item it holds.
   assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && v4_ff && !rsp_tready) |=>
      (v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("item lost from a stalled pipeline");

   // A product of two unit-bounded values stays within one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[71:64]) >= -8'sd64 &&
                      $signed(rsp_tdata[71:64]) <= 8'sd64))
      else $error("r22 out of the unit range");

endmodule
